// ----- hdl/mdf_pkg.sv -----
// shared types and constants of the 3x3 median despeckle filter
`timescale 1ns / 1ps

package mdf_pkg;

    // geometry and sample format
    localparam int PIX_W      = 16;
    localparam int MASK_W     = 9;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 2) + 1;
    localparam int SIZE_W     = 11;
    localparam int SUM_W      = PIX_W + 4;
    localparam int PIX_MAX    = (1 << PIX_W) - 1;
    localparam int Q_ONE      = 256;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESPECKLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENHANCE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRAY_ONLY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    // stray threshold: (THR_BASE - THR_STEP * despeckle) of full scale / 25600
    localparam int THR_BASE  = 6400;
    localparam int THR_STEP  = 23;
    localparam int THR_SCALE = 25600;

    // rounding division by 9216 = 1024 * 9, the 9 through a reciprocal
    localparam int BLEND_ONE   = 9216;
    localparam int BLEND_HALF  = 4608;
    localparam int DIV9_SHIFT  = 24;
    localparam int DIV9_RECIP  = 1864136;

    typedef logic [PIX_W-1:0] t_pix;

    // one window handed to the filter kernel
    typedef struct packed {
        logic [8:0][PIX_W-1:0] samples;
        t_pix                  center;
        logic [MASK_W-1:0]     mask;
        logic                  last;
    } t_job;

    // filter settings, already clamped
    typedef struct packed {
        logic [8:0] strength;
        logic [8:0] despeckle;
        logic       enhance;
        logic       stray_only;
    } t_kcfg;

    typedef struct packed {
        t_pix height;
        logic stray;
        logic last;
    } t_res;

endpackage

// ----- hdl/mdf_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module mdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- hdl/mdf_kernel.sv -----
// window kernel: sequenced sort for the median, then threshold and blend stages
`timescale 1ns / 1ps

module mdf_kernel (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mdf_pkg::t_job i_job,
    input  mdf_pkg::t_kcfg i_cfg,
    input  logic          i_take,
    output logic          o_busy,
    output logic          o_hold,
    output mdf_pkg::t_res o_result
);

    localparam logic [3:0] K_IDLE = 4'd0;
    localparam logic [3:0] K_SORT = 4'd1;
    localparam logic [3:0] K_S1   = 4'd2;
    localparam logic [3:0] K_S2   = 4'd3;
    localparam logic [3:0] K_S3   = 4'd4;
    localparam logic [3:0] K_S4   = 4'd5;
    localparam logic [3:0] K_S5   = 4'd6;
    localparam logic [3:0] K_S6   = 4'd7;
    localparam logic [3:0] K_HOLD = 4'd8;

    logic [3:0] r_state;
    logic [3:0] r_pass;

    mdf_pkg::t_pix r_v [9];
    mdf_pkg::t_pix n_v [9];
    mdf_pkg::t_pix r_c;
    logic [mdf_pkg::MASK_W-1:0] r_m;
    logic r_last;
    logic [mdf_pkg::SUM_W-1:0] r_sum;

    mdf_pkg::t_pix r_dev;
    logic [mdf_pkg::SUM_W-1:0] r_con9;
    logic signed [16:0] r_diff;
    logic signed [20:0] r_det;
    logic r_stray;
    logic signed [32:0] r_p1;
    logic signed [30:0] r_p2;
    logic [20:0] r_x;
    logic r_neg;
    logic [17:0] r_q;
    logic signed [16:0] r_diff2;
    mdf_pkg::t_pix r_res;

    logic [mdf_pkg::SUM_W-1:0] job_sum;
    logic [mdf_pkg::SUM_W-1:0] c9;
    logic signed [20:0] det;
    logic [mdf_pkg::SUM_W-1:0] con9;
    logic signed [16:0] diff;
    mdf_pkg::t_pix med;
    mdf_pkg::t_pix dev;
    logic [12:0] tq;
    logic [39:0] thr;
    logic stray;
    logic [14:0] st36;
    logic signed [32:0] p1;
    logic signed [30:0] p2;
    logic signed [34:0] cterm;
    logic signed [34:0] num;
    logic signed [34:0] numr;
    logic [41:0] prod;
    logic [21:0] r9;
    logic [17:0] qc;
    mdf_pkg::t_pix cand;
    logic signed [16:0] diff2;
    logic signed [26:0] t;
    logic signed [26:0] t2;
    logic signed [26:0] sh;

    assign o_busy = (r_state != K_IDLE);
    assign o_hold = (r_state == K_HOLD);
    assign o_result.height = r_res;
    assign o_result.stray  = r_stray;
    assign o_result.last   = r_last;

    // window sum at load
    always_comb begin
        job_sum = '0;
        for (int i = 0; i < 9; i++) begin
            job_sum = job_sum + mdf_pkg::SUM_W'(i_job.samples[i]);
        end
    end

    // one odd-even transposition pass
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_v[i] = r_v[i];
        end
        for (int i = 0; i < 8; i++) begin
            if (((i % 2) == int'(r_pass[0])) && (r_v[i] > r_v[i+1])) begin
                n_v[i]   = r_v[i+1];
                n_v[i+1] = r_v[i];
            end
        end
    end

    // deviation and contrast terms
    always_comb begin
        med  = r_v[4];
        dev  = (r_c > med) ? (r_c - med) : (med - r_c);
        c9   = (mdf_pkg::SUM_W'(r_c) << 3) + mdf_pkg::SUM_W'(r_c);
        det  = $signed({1'b0, c9}) - $signed({1'b0, r_sum});
        con9 = det[20] ? mdf_pkg::SUM_W'(-det) : det[mdf_pkg::SUM_W-1:0];
        diff = $signed({1'b0, med}) - $signed({1'b0, r_c});
    end

    // stray test and blend products
    always_comb begin
        tq    = 13'(mdf_pkg::THR_BASE) - 13'(mdf_pkg::THR_STEP * int'(i_cfg.despeckle));
        thr   = 40'(tq) << mdf_pkg::PIX_W;
        stray = (40'(r_dev) * 40'(mdf_pkg::THR_SCALE) >= thr) ||
                (40'(r_con9) * 40'(mdf_pkg::THR_SCALE) >= thr * 40'd9);
        st36  = 15'(i_cfg.strength) * 15'd36;
        p1    = $signed({1'b0, st36}) * r_diff;
        p2    = $signed({1'b0, i_cfg.strength}) * r_det;
    end

    // numerator and coarse quotient
    always_comb begin
        cterm = $signed(35'(r_c) * 35'(mdf_pkg::BLEND_ONE));
        num   = cterm + 35'(r_p1) + (i_cfg.enhance ? 35'(r_p2) : 35'sd0);
        numr  = num + 35'(mdf_pkg::BLEND_HALF);
        prod  = 42'(r_x) * 42'(mdf_pkg::DIV9_RECIP);
    end

    // quotient fixup, saturation and mask blend
    always_comb begin
        r9 = 22'(r_x) - 22'(r_q) * 22'd9;
        qc = (r9 >= 22'd9) ? (r_q + 18'd1) : r_q;
        if (r_neg) begin
            cand = '0;
        end else if (qc > 18'(mdf_pkg::PIX_MAX)) begin
            cand = mdf_pkg::t_pix'(mdf_pkg::PIX_MAX);
        end else begin
            cand = qc[mdf_pkg::PIX_W-1:0];
        end
        if (i_cfg.stray_only && !r_stray) begin
            cand = r_c;
        end
        diff2 = $signed({1'b0, cand}) - $signed({1'b0, r_c});
        t     = $signed({1'b0, r_m}) * r_diff2;
        t2    = t + 27'sd128;
        sh    = t2 >>> 8;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
            r_pass  <= '0;
        end else begin
            unique case (r_state)
                K_IDLE: begin
                    if (i_start) begin
                        r_state <= K_SORT;
                        r_pass  <= '0;
                    end
                end
                K_SORT: begin
                    r_pass <= r_pass + 4'd1;
                    if (r_pass == 4'd8) begin
                        r_state <= K_S1;
                    end
                end
                K_S1: r_state <= K_S2;
                K_S2: r_state <= K_S3;
                K_S3: r_state <= K_S4;
                K_S4: r_state <= K_S5;
                K_S5: r_state <= K_S6;
                K_S6: r_state <= K_HOLD;
                K_HOLD: begin
                    if (i_take) begin
                        r_state <= K_IDLE;
                    end
                end
                default: r_state <= K_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == K_IDLE) && i_start) begin
            for (int i = 0; i < 9; i++) begin
                r_v[i] <= i_job.samples[i];
            end
            r_c    <= i_job.center;
            r_m    <= i_job.mask;
            r_last <= i_job.last;
            r_sum  <= job_sum;
        end
        if (r_state == K_SORT) begin
            for (int i = 0; i < 9; i++) begin
                r_v[i] <= n_v[i];
            end
        end
        if (r_state == K_S1) begin
            r_dev  <= dev;
            r_con9 <= con9;
            r_diff <= diff;
            r_det  <= det;
        end
        if (r_state == K_S2) begin
            r_stray <= stray;
            r_p1    <= p1;
            r_p2    <= p2;
        end
        if (r_state == K_S3) begin
            r_x   <= numr[30:10];
            r_neg <= num[34];
        end
        if (r_state == K_S4) begin
            r_q <= prod[41:mdf_pkg::DIV9_SHIFT];
        end
        if (r_state == K_S5) begin
            r_diff2 <= diff2;
        end
        if (r_state == K_S6) begin
            r_res <= r_c + sh[mdf_pkg::PIX_W-1:0];
        end
    end

endmodule

// ----- hdl/median_despeckle_filter_3x3.sv -----
// 3x3 median despeckle filter top level: line buffers, window and frame control
// Path: a window completes with the transfer one row plus one pixel after its center pixel;
//   the result passes the update state, kernel sort and stages, hold and output register.
// Flow: a transfer that is not ignored stalls the next for the update state; one that emits a
//   result holds off the next through 9 sort passes, 6 stages and the output hand-off.
// Reset: synchronous active low; config to defaults, counters and window clear, rams kept.
`timescale 1ns / 1ps

module median_despeckle_filter_3x3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mdf_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [15:0]                   i_pixel_in,
    input  logic [8:0]                    i_mask_weight,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [15:0]                   o_filtered_height,
    output logic                          o_stray_flag,
    output logic                          o_frame_last
);

    localparam logic T_IDLE   = 1'b0;
    localparam logic T_UPDATE = 1'b1;

    localparam int AW = mdf_pkg::ADDR_W;
    localparam int RW = mdf_pkg::ROW_W;
    localparam int SW = mdf_pkg::SIZE_W;

    // configuration
    logic [8:0]    r_strength;
    logic [8:0]    r_despeckle;
    logic          r_enhance;
    logic          r_stray_only;
    logic [SW-1:0] r_frame_width;
    logic [SW-1:0] r_frame_height;

    // frame state
    logic          r_state;
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_pend;
    mdf_pkg::t_pix r_win [9];
    logic [8:0]    r_mask_prev;

    // held item
    mdf_pkg::t_pix r_p;
    logic [8:0]    r_mw;

    // output register
    logic          r_out_valid;
    mdf_pkg::t_res r_out;

    logic [SW-1:0] width;
    logic [SW-1:0] height;
    logic [RW-1:0] height_r;
    logic          accept;
    logic          restart;
    logic [AW-1:0] eff_col;
    logic [RW-1:0] eff_row;
    logic          eff_pend;
    logic          ignore;

    mdf_pkg::t_pix rd_above;
    mdf_pkg::t_pix rd_center;
    logic [8:0]    rd_mask;

    logic          fin;
    logic          row_pix;
    logic          emit_a;
    logic          emit_b;
    mdf_pkg::t_pix p_eff;
    mdf_pkg::t_pix a_val;
    logic [SW-1:0] col_inc;
    logic          we_center;
    logic          we_above;
    logic          we_mask;

    mdf_pkg::t_job  job;
    mdf_pkg::t_kcfg kcfg;
    mdf_pkg::t_res  kres;
    logic           k_busy;
    logic           k_hold;
    logic           k_take;
    logic           k_start;

    // clamped frame size
    always_comb begin
        if (r_frame_width == '0) begin
            width = SW'(1);
        end else if (r_frame_width > SW'(mdf_pkg::MAX_WIDTH)) begin
            width = SW'(mdf_pkg::MAX_WIDTH);
        end else begin
            width = r_frame_width;
        end
        if (r_frame_height == '0) begin
            height = SW'(1);
        end else if (r_frame_height > SW'(mdf_pkg::MAX_HEIGHT)) begin
            height = SW'(mdf_pkg::MAX_HEIGHT);
        end else begin
            height = r_frame_height;
        end
        height_r = RW'(height);
    end

    // input transfer and restart check
    assign o_in_stall = (r_state != T_IDLE) || k_busy;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        restart  = (SW'(r_col) >= width) || (r_row > height_r + RW'(1));
        eff_col  = restart ? '0 : r_col;
        eff_row  = restart ? '0 : r_row;
        eff_pend = restart ? 1'b0 : r_pend;
        ignore   = (eff_row < height_r) ? i_mode : !i_mode;
    end

    // line buffers
    mdf_ram #(.WIDTH(mdf_pkg::PIX_W), .DEPTH(mdf_pkg::MAX_WIDTH)) u_line_above (
        .i_clk   (i_clk),
        .i_we    (we_above),
        .i_waddr (r_col),
        .i_wdata (rd_center),
        .i_re    (accept),
        .i_raddr (eff_col),
        .o_rdata (rd_above)
    );

    mdf_ram #(.WIDTH(mdf_pkg::PIX_W), .DEPTH(mdf_pkg::MAX_WIDTH)) u_line_center (
        .i_clk   (i_clk),
        .i_we    (we_center),
        .i_waddr (r_col),
        .i_wdata (p_eff),
        .i_re    (accept),
        .i_raddr (eff_col),
        .o_rdata (rd_center)
    );

    mdf_ram #(.WIDTH(mdf_pkg::MASK_W), .DEPTH(mdf_pkg::MAX_WIDTH)) u_mask_line (
        .i_clk   (i_clk),
        .i_we    (we_mask),
        .i_waddr (r_col),
        .i_wdata (r_mw),
        .i_re    (accept),
        .i_raddr (eff_col),
        .o_rdata (rd_mask)
    );

    // update decisions
    always_comb begin
        fin       = (r_row == height_r + RW'(1));
        row_pix   = (r_row < height_r);
        emit_a    = r_pend && (fin || (r_col == '0));
        emit_b    = !fin && (r_row != '0) && (r_col != '0);
        p_eff     = row_pix ? r_p : rd_center;
        a_val     = (r_row == RW'(1)) ? rd_center : rd_above;
        col_inc   = SW'(r_col) + SW'(1);
        we_center = (r_state == T_UPDATE) && !fin;
        we_above  = (r_state == T_UPDATE) && !fin && (r_row != '0);
        we_mask   = (r_state == T_UPDATE) && !fin && row_pix;
        k_start   = (r_state == T_UPDATE) && (emit_a || emit_b);
    end

    // window for the kernel
    always_comb begin
        job.center = r_win[7];
        job.mask   = r_mask_prev;
        job.last   = fin;
        job.samples[3] = r_win[6];
        job.samples[4] = r_win[7];
        job.samples[5] = r_win[8];
        if (emit_a) begin
            job.samples[6] = r_win[6];
            job.samples[7] = r_win[7];
            job.samples[8] = r_win[8];
            if (width == SW'(1)) begin
                job.samples[0] = r_win[6];
                job.samples[1] = r_win[7];
                job.samples[2] = r_win[8];
            end else begin
                job.samples[0] = r_win[3];
                job.samples[1] = r_win[4];
                job.samples[2] = r_win[5];
            end
        end else begin
            job.samples[6] = a_val;
            job.samples[7] = rd_center;
            job.samples[8] = p_eff;
            if (r_col == AW'(1)) begin
                job.samples[0] = r_win[6];
                job.samples[1] = r_win[7];
                job.samples[2] = r_win[8];
            end else begin
                job.samples[0] = r_win[3];
                job.samples[1] = r_win[4];
                job.samples[2] = r_win[5];
            end
        end
    end

    assign kcfg.strength   = (r_strength > 9'(mdf_pkg::Q_ONE)) ? 9'(mdf_pkg::Q_ONE) : r_strength;
    assign kcfg.despeckle  = (r_despeckle > 9'(mdf_pkg::Q_ONE)) ? 9'(mdf_pkg::Q_ONE)
                                                                 : r_despeckle;
    assign kcfg.enhance    = r_enhance;
    assign kcfg.stray_only = r_stray_only;

    assign k_take = k_hold && (!r_out_valid || !i_out_stall);

    mdf_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (k_start),
        .i_job    (job),
        .i_cfg    (kcfg),
        .i_take   (k_take),
        .o_busy   (k_busy),
        .o_hold   (k_hold),
        .o_result (kres)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength     <= 9'd128;
            r_despeckle    <= 9'd64;
            r_enhance      <= 1'b0;
            r_stray_only   <= 1'b0;
            r_frame_width  <= SW'(1024);
            r_frame_height <= SW'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mdf_pkg::REG_STRENGTH:     r_strength     <= i_cfg_data[8:0];
                mdf_pkg::REG_DESPECKLE:    r_despeckle    <= i_cfg_data[8:0];
                mdf_pkg::REG_ENHANCE:      r_enhance      <= i_cfg_data[0];
                mdf_pkg::REG_STRAY_ONLY:   r_stray_only   <= i_cfg_data[0];
                mdf_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[SW-1:0];
                mdf_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // frame control and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_pend      <= 1'b0;
            r_mask_prev <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_col  <= eff_col;
                        r_row  <= eff_row;
                        r_pend <= eff_pend;
                        if (!ignore) begin
                            r_state <= T_UPDATE;
                        end
                    end
                end
                T_UPDATE: begin
                    r_state <= T_IDLE;
                    if (fin) begin
                        r_col  <= '0;
                        r_row  <= '0;
                        r_pend <= 1'b0;
                    end else begin
                        if (r_row != '0) begin
                            for (int i = 0; i < 6; i++) begin
                                r_win[i] <= r_win[i+3];
                            end
                            r_win[6]    <= a_val;
                            r_win[7]    <= rd_center;
                            r_win[8]    <= p_eff;
                            r_mask_prev <= rd_mask;
                        end
                        if ((r_row != '0) && (SW'(r_col) == width - SW'(1))) begin
                            r_pend <= 1'b1;
                        end else if (emit_a) begin
                            r_pend <= 1'b0;
                        end
                        if (col_inc >= width) begin
                            r_col <= '0;
                            r_row <= r_row + RW'(1);
                        end else begin
                            r_col <= col_inc[AW-1:0];
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // held item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p     <= i_pixel_in;
            r_mw    <= (i_mask_weight > 9'(mdf_pkg::Q_ONE)) ? 9'(mdf_pkg::Q_ONE)
                                                             : i_mask_weight;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (k_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (k_take) begin
            r_out <= kres;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_height = r_out.height;
    assign o_stray_flag      = r_out.stray;
    assign o_frame_last      = r_out.last;

endmodule
